[rtl/probabilistic_step_sequencer_top_defines.svh]
// assertion macros for the step sequencer
`ifndef PROBABILISTIC_STEP_SEQUENCER_TOP_DEFINES_SVH
`define PROBABILISTIC_STEP_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTH
`define PSS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");
`else
`define PSS_ASSERT_NOW(lbl, ante, cons)
`define PSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/pss_pkg.sv]
package pss_pkg;

	localparam int NUM_TRACKS = 8;
	localparam int NUM_STEPS  = 16;
	localparam int NUM_GATES  = NUM_TRACKS + 1;
	localparam int IDX_W      = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

	localparam int STEP_W  = 4;
	localparam int MS_W    = 16;
	localparam int PCT_W   = 7;
	localparam int ROLL_W  = 7;
	localparam int BITS_W  = 8;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 16;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_GRID = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_PLAYING     = 3'd0,
		CFG_INTERVAL    = 3'd1,
		CFG_ONTIME      = 3'd2,
		CFG_DRUNK       = 3'd3,
		CFG_PROBABILITY = 3'd4,
		CFG_RANGE_START = 3'd5,
		CFG_RANGE_END   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic                 tick;
		logic [NUM_GATES-1:0] fire;
		logic [MS_W-1:0]      ontime;
	} gate_ctl_t;

endpackage

[rtl/pss_gates.sv]
module pss_gates
	import pss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  gate_ctl_t            ctl,
	output logic [NUM_GATES-1:0] active_nxt
);

	logic [MS_W-1:0]      rem_q [NUM_GATES];
	logic [MS_W-1:0]      rem_d [NUM_GATES];
	logic [NUM_GATES-1:0] act_q;

	always_comb begin
		for (int g = 0; g < NUM_GATES; g++) begin
			rem_d[g]      = rem_q[g];
			active_nxt[g] = act_q[g];
			// countdown first, then a new fire reloads
			if (ctl.tick && act_q[g]) begin
				if (rem_q[g] <= MS_W'(1)) begin
					rem_d[g]      = '0;
					active_nxt[g] = 1'b0;
				end else begin
					rem_d[g] = rem_q[g] - MS_W'(1);
				end
			end
			if (ctl.fire[g]) begin
				rem_d[g]      = ctl.ontime;
				active_nxt[g] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			for (int g = 0; g < NUM_GATES; g++) begin
				rem_q[g] <= '0;
			end
		end else if (load) begin
			act_q <= active_nxt;
			for (int g = 0; g < NUM_GATES; g++) begin
				rem_q[g] <= rem_d[g];
			end
		end
	end

endmodule

[rtl/probabilistic_step_sequencer_top.sv]
// the result beat is registered and is presented in the cycle after its input beat is accepted
// throughput: one beat per cycle while out_ready is high; the output register frees as it is taken
// all sequencer state updates happen in the accepting cycle, the result register follows
// reset (arst_n low, asynchronous): grid cleared, step and counters zero,
// gates and led off, configuration registers back to their default values
`include "probabilistic_step_sequencer_top_defines.svh"

module probabilistic_step_sequencer_top
	import pss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [ROLL_W-1:0]   dir_roll,
	input  logic [55:0]         track_rolls,
	input  logic [STEP_W-1:0]   grid_step,
	input  logic [BITS_W-1:0]   grid_bits,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BITS_W-1:0]   gate_bits,
	output logic                led_on,
	output logic [STEP_W-1:0]   step_index,
	output logic                stepped,
	output logic                reversed,
	output logic [BITS_W-1:0]   fired_bits
);

	function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] s);
		logic [STEP_W-1:0] r;
		r = (32'(s) > NUM_STEPS - 1) ? STEP_W'(NUM_STEPS - 1) : s;
		return r;
	endfunction

	// configuration registers
	logic              playing_q;
	logic [MS_W-1:0]   interval_q;
	logic [MS_W-1:0]   ontime_q;
	logic [PCT_W-1:0]  drunk_q;
	logic [PCT_W-1:0]  prob_q;
	logic [STEP_W-1:0] range_start_q;
	logic [STEP_W-1:0] range_end_q;

	// sequencer state
	logic [NUM_TRACKS-1:0] grid_q [NUM_STEPS];
	logic [STEP_W-1:0]     cur_step_q;
	logic [MS_W-1:0]       elapsed_q;

	// result register
	logic              out_valid_q;
	logic [BITS_W-1:0] gate_bits_q;
	logic              led_on_q;
	logic [STEP_W-1:0] step_index_q;
	logic              stepped_q;
	logic              reversed_q;
	logic [BITS_W-1:0] fired_bits_q;

	logic                  in_fire;
	logic                  tick;
	logic                  grid_wr;
	logic [MS_W-1:0]       elapsed_inc;
	logic                  do_step;
	logic                  rev;
	logic [STEP_W-1:0]     lo;
	logic [STEP_W-1:0]     hi;
	logic signed [STEP_W+1:0] s_a;
	logic signed [STEP_W+1:0] s_b;
	logic [STEP_W-1:0]     step_nxt;
	logic [NUM_TRACKS-1:0] col;
	logic [NUM_TRACKS-1:0] fire;
	gate_ctl_t             gctl;
	logic [NUM_GATES-1:0]  gates_nxt;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign tick     = in_fire && (cmd_t'(command) == CMD_TICK);
	assign grid_wr  = in_fire && (cmd_t'(command) == CMD_GRID) && (32'(grid_step) < NUM_STEPS);

	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + MS_W'(1) : elapsed_q;
	assign do_step     = tick && playing_q && (elapsed_inc >= interval_q);
	assign rev         = dir_roll < drunk_q;
	assign lo          = clamp_step(range_start_q);
	assign hi          = clamp_step(range_end_q);

	// step by one, then wrap inside the range (order matters for an inverted range)
	always_comb begin
		s_a = rev ? ($signed({2'b00, cur_step_q}) - (STEP_W+2)'(1))
		          : ($signed({2'b00, cur_step_q}) + (STEP_W+2)'(1));
		s_b = s_a;
		if (s_b < $signed({2'b00, lo})) begin
			s_b = $signed({2'b00, hi});
		end
		if (s_b > $signed({2'b00, hi})) begin
			s_b = $signed({2'b00, lo});
		end
		step_nxt = s_b[STEP_W-1:0];
	end

	always_comb begin
		col = '0;
		if (32'(step_nxt) < NUM_STEPS) begin
			col = grid_q[IDX_W'(step_nxt)];
		end
		for (int t = 0; t < NUM_TRACKS; t++) begin
			fire[t] = do_step && col[t] && (track_rolls[ROLL_W*t +: ROLL_W] < prob_q);
		end
	end

	assign gctl.tick   = tick;
	assign gctl.fire   = {do_step, fire};
	assign gctl.ontime = ontime_q;

	pss_gates u_gates (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_fire),
		.ctl        (gctl),
		.active_nxt (gates_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q     <= 1'b0;
			interval_q    <= MS_W'(125);
			ontime_q      <= MS_W'(10);
			drunk_q       <= '0;
			prob_q        <= PCT_W'(100);
			range_start_q <= '0;
			range_end_q   <= STEP_W'(15);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PLAYING:     playing_q     <= cfg_wdata[0];
				CFG_INTERVAL:    interval_q    <= cfg_wdata[MS_W-1:0];
				CFG_ONTIME:      ontime_q      <= cfg_wdata[MS_W-1:0];
				CFG_DRUNK:       drunk_q       <= cfg_wdata[PCT_W-1:0];
				CFG_PROBABILITY: prob_q        <= cfg_wdata[PCT_W-1:0];
				CFG_RANGE_START: range_start_q <= cfg_wdata[STEP_W-1:0];
				CFG_RANGE_END:   range_end_q   <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STEPS; i++) begin
				grid_q[i] <= '0;
			end
			cur_step_q <= '0;
			elapsed_q  <= '0;
		end else begin
			if (grid_wr) begin
				grid_q[IDX_W'(grid_step)] <= grid_bits[NUM_TRACKS-1:0];
			end
			if (tick) begin
				elapsed_q <= do_step ? '0 : elapsed_inc;
			end
			if (do_step) begin
				cur_step_q <= step_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			gate_bits_q  <= BITS_W'(gates_nxt[NUM_TRACKS-1:0]);
			led_on_q     <= gates_nxt[NUM_TRACKS];
			step_index_q <= do_step ? step_nxt : cur_step_q;
			stepped_q    <= do_step;
			reversed_q   <= do_step && rev;
			fired_bits_q <= BITS_W'(fire);
		end
	end

	assign out_valid  = out_valid_q;
	assign gate_bits  = gate_bits_q;
	assign led_on     = led_on_q;
	assign step_index = step_index_q;
	assign stepped    = stepped_q;
	assign reversed   = reversed_q;
	assign fired_bits = fired_bits_q;

	`PSS_ASSERT_NOW(a_fired_gated, out_valid, (fired_bits & ~gate_bits) == '0)
	`PSS_ASSERT_NOW(a_quiet_no_step, out_valid && !stepped, fired_bits == '0 && !reversed)
	`PSS_ASSERT_NOW(a_step_led, out_valid && stepped, led_on)
	`PSS_ASSERT_NEXT(a_grid_keeps_step, in_fire && command == CMD_GRID, $stable(cur_step_q))

endmodule

[tb/sv/probabilistic_step_sequencer_top_tb.sv]
module probabilistic_step_sequencer_top_tb;
	import pss_pkg::*;

	typedef struct packed {
		logic [BITS_W-1:0] gates;
		logic              led;
		logic [STEP_W-1:0] step;
		logic              adv;
		logic              back;
		logic [BITS_W-1:0] fired;
	} seq_out_t;

	typedef struct {
		bit                is_cfg;
		cfg_idx_t          idx;
		logic [CFG_DW-1:0] data;
		cmd_t              cmd;
		logic [ROLL_W-1:0] dir;
		logic [55:0]       rolls;
		logic [STEP_W-1:0] gstep;
		logic [BITS_W-1:0] gbits;
		bit                typed;
		seq_out_t          want;
	} plan_row_t;

	localparam int STALL_LIMIT = 1000;
	localparam seq_out_t QUIET = '0;
	localparam logic [55:0] ROLL_MIX =
		{7'd127, 7'd100, 7'd99, 7'd0, 7'd127, 7'd100, 7'd99, 7'd0};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              command = 1'b0;
	logic [ROLL_W-1:0] dir_roll = '0;
	logic [55:0]       track_rolls = '0;
	logic [STEP_W-1:0] grid_step = '0;
	logic [BITS_W-1:0] grid_bits = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BITS_W-1:0] gate_bits;
	logic              led_on;
	logic [STEP_W-1:0] step_index;
	logic              stepped;
	logic              reversed;
	logic [BITS_W-1:0] fired_bits;

	probabilistic_step_sequencer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.dir_roll(dir_roll),
		.track_rolls(track_rolls),
		.grid_step(grid_step),
		.grid_bits(grid_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gate_bits(gate_bits),
		.led_on(led_on),
		.step_index(step_index),
		.stepped(stepped),
		.reversed(reversed),
		.fired_bits(fired_bits)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// sequencer shadow state
	logic [BITS_W-1:0] m_grid [NUM_STEPS];
	logic [STEP_W-1:0] m_step;
	logic [MS_W-1:0]   m_elapsed;
	logic [MS_W-1:0]   m_gate_left [NUM_TRACKS];
	logic [BITS_W-1:0] m_gate_on;
	logic [MS_W:0]     m_led_left;
	logic              m_led_lit;
	logic              m_playing;
	logic [MS_W-1:0]   m_interval;
	logic [MS_W-1:0]   m_ontime;
	logic [PCT_W-1:0]  m_drunk;
	logic [PCT_W-1:0]  m_prob;
	logic [STEP_W-1:0] m_rstart;
	logic [STEP_W-1:0] m_rend;

	seq_out_t  pending_outs [$];
	plan_row_t plan [$];
	bit        idle_on = 1'b1;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        stall_left = 0;

	function automatic void model_reset();
		for (int i = 0; i < NUM_STEPS; i++) m_grid[i] = '0;
		for (int t = 0; t < NUM_TRACKS; t++) m_gate_left[t] = '0;
		m_step = '0;
		m_elapsed = '0;
		m_gate_on = '0;
		m_led_left = '0;
		m_led_lit = 1'b0;
		m_playing = 1'b0;
		m_interval = MS_W'(125);
		m_ontime = MS_W'(10);
		m_drunk = '0;
		m_prob = PCT_W'(100);
		m_rstart = '0;
		m_rend = STEP_W'(15);
	endfunction

	function automatic void model_config(cfg_idx_t idx, logic [CFG_DW-1:0] d);
		case (idx)
			CFG_PLAYING:     m_playing = d[0];
			CFG_INTERVAL:    m_interval = d[MS_W-1:0];
			CFG_ONTIME:      m_ontime = d[MS_W-1:0];
			CFG_DRUNK:       m_drunk = d[PCT_W-1:0];
			CFG_PROBABILITY: m_prob = d[PCT_W-1:0];
			CFG_RANGE_START: m_rstart = d[STEP_W-1:0];
			CFG_RANGE_END:   m_rend = d[STEP_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic seq_out_t sequencer_result(cmd_t cmd, logic [ROLL_W-1:0] dir,
			logic [55:0] rolls, logic [STEP_W-1:0] gstep, logic [BITS_W-1:0] gbits);
		seq_out_t r;
		int s, lo, hi;
		logic [BITS_W-1:0] col;
		logic [BITS_W-1:0] tmask;
		r = '0;
		tmask = BITS_W'((1 << NUM_TRACKS) - 1);
		if (cmd == CMD_GRID) begin
			if (int'(gstep) < NUM_STEPS) m_grid[gstep] = gbits & tmask;
		end else begin
			// expire gates first
			for (int t = 0; t < NUM_TRACKS; t++) begin
				if (m_gate_on[t]) begin
					if (m_gate_left[t] <= 1) begin
						m_gate_left[t] = '0;
						m_gate_on[t] = 1'b0;
					end else begin
						m_gate_left[t] = m_gate_left[t] - 1'b1;
					end
				end
			end
			if (m_led_lit) begin
				if (m_led_left <= 1) begin
					m_led_left = '0;
					m_led_lit = 1'b0;
				end else begin
					m_led_left = m_led_left - 1'b1;
				end
			end
			if (m_elapsed != '1) m_elapsed = m_elapsed + 1'b1;
			if (m_playing && m_elapsed >= m_interval) begin
				m_elapsed = '0;
				r.adv = 1'b1;
				r.back = (dir < m_drunk);
				lo = (int'(m_rstart) > NUM_STEPS - 1) ? NUM_STEPS - 1 : int'(m_rstart);
				hi = (int'(m_rend) > NUM_STEPS - 1) ? NUM_STEPS - 1 : int'(m_rend);
				s = int'(m_step) + (r.back ? -1 : 1);
				if (s < lo) s = hi;
				if (s > hi) s = lo;
				m_step = STEP_W'(s);
				m_led_lit = 1'b1;
				m_led_left = {1'b0, m_ontime};
				col = (int'(m_step) < NUM_STEPS) ? m_grid[m_step] : '0;
				for (int t = 0; t < NUM_TRACKS; t++) begin
					if (col[t] && rolls[ROLL_W*t +: ROLL_W] < m_prob) begin
						r.fired[t] = 1'b1;
						m_gate_on[t] = 1'b1;
						m_gate_left[t] = m_ontime;
					end
				end
			end
		end
		r.gates = m_gate_on;
		r.led = m_led_lit;
		r.step = m_step;
		return r;
	endfunction

	function automatic void plan_cfg(cfg_idx_t idx, logic [CFG_DW-1:0] d);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = d;
		row.cmd = CMD_TICK;
		row.dir = '0;
		row.rolls = '0;
		row.gstep = '0;
		row.gbits = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_item(cmd_t cmd, logic [ROLL_W-1:0] dir, logic [55:0] rolls,
			logic [STEP_W-1:0] gstep, logic [BITS_W-1:0] gbits,
			bit typed = 1'b0, seq_out_t want = '0);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx = CFG_PLAYING;
		row.data = '0;
		row.cmd = cmd;
		row.dir = dir;
		row.rolls = rolls;
		row.gstep = gstep;
		row.gbits = gbits;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	function automatic logic [CFG_DW-1:0] pick_value(cfg_idx_t idx);
		int r;
		r = $urandom_range(0, 9);
		case (idx)
			CFG_PLAYING:
				return (r < 8) ? CFG_DW'(1) : CFG_DW'(0);
			CFG_INTERVAL, CFG_ONTIME: begin
				if (r == 0) return '0;
				if (r == 1) return '1;
				if (r == 2) return CFG_DW'($urandom);
				return CFG_DW'($urandom_range(1, 6));
			end
			CFG_DRUNK, CFG_PROBABILITY: begin
				if (r == 0) return '0;
				if (r == 1) return CFG_DW'(100);
				return CFG_DW'($urandom_range(0, 100));
			end
			default:
				return CFG_DW'($urandom_range(0, NUM_STEPS - 1));
		endcase
	endfunction

	task automatic cfg_write(cfg_idx_t idx, logic [CFG_DW-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		model_config(idx, d);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_outs.size() != 0) @(posedge clk);
	endtask

	task automatic drive_beat(cmd_t cmd, logic [ROLL_W-1:0] dir, logic [55:0] rolls,
			logic [STEP_W-1:0] gstep, logic [BITS_W-1:0] gbits,
			bit typed, seq_out_t want);
		seq_out_t pred;
		cfg_we <= 1'b0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		dir_roll <= dir;
		track_rolls <= rolls;
		grid_step <= gstep;
		grid_bits <= gbits;
		do @(posedge clk); while (!in_ready);
		pred = sequencer_result(cmd, dir, rolls, gstep, gbits);
		pending_outs.push_back(typed ? want : pred);
	endtask

	task automatic random_beat(bit ticks_only);
		cmd_t cmd;
		cmd = (!ticks_only && $urandom_range(0, 9) == 0) ? CMD_GRID : CMD_TICK;
		drive_beat(cmd, ROLL_W'($urandom), 56'({$urandom, $urandom}),
			STEP_W'($urandom), BITS_W'($urandom), 1'b0, '0);
	endtask

	task automatic shuffle_cfg(bit all_regs);
		for (int i = 0; i <= int'(CFG_RANGE_END); i++) begin
			if (all_regs || $urandom_range(0, 1) == 0)
				cfg_write(cfg_idx_t'(i), pick_value(cfg_idx_t'(i)));
		end
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		seq_out_t got;
		seq_out_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {gate_bits, led_on, step_index, stepped, reversed, fired_bits};
			if (pending_outs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: gates=%h led=%b step=%0d stepped=%b rev=%b fired=%h",
						got.gates, got.led, got.step, got.adv, got.back, got.fired);
			end else begin
				want = pending_outs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: gates=%h led=%b step=%0d stepped=%b rev=%b fired=%h",
							want.gates, want.led, want.step, want.adv, want.back, want.fired);
						$display("         got: gates=%h led=%b step=%0d stepped=%b rev=%b fired=%h",
							got.gates, got.led, got.step, got.adv, got.back, got.fired);
					end
				end
			end
		end
		if (!idle_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("probabilistic_step_sequencer_top_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, field extremes, wraps, inverted range, gate ends
		plan_item(CMD_TICK, 7'd0, '0, 4'd0, 8'h00, 1'b1, QUIET);
		plan_item(CMD_TICK, 7'h7F, '1, 4'hF, 8'hFF, 1'b1, QUIET);
		plan_item(CMD_GRID, 7'h7F, '1, 4'hF, 8'hFF, 1'b1, QUIET);
		plan_item(CMD_GRID, 7'd0, '0, 4'd0, 8'h00, 1'b1, QUIET);
		plan_item(CMD_GRID, 7'd0, '0, 4'd1, 8'hA5, 1'b1, QUIET);
		plan_item(CMD_GRID, 7'd0, '0, 4'd2, 8'h5A, 1'b1, QUIET);
		plan_cfg(CFG_PLAYING, 16'd1);
		plan_cfg(CFG_INTERVAL, 16'd0);
		plan_cfg(CFG_ONTIME, 16'd0);
		plan_item(CMD_TICK, 7'd0, '0, 4'd0, 8'h00, 1'b1,
			seq_out_t'{8'hA5, 1'b1, 4'd1, 1'b1, 1'b0, 8'hA5});
		plan_item(CMD_TICK, 7'd99, '1, 4'd0, 8'h00);
		plan_cfg(CFG_DRUNK, 16'd100);
		repeat (4) plan_item(CMD_TICK, 7'd99, ROLL_MIX, 4'd0, 8'h00);
		plan_item(CMD_TICK, 7'h7F, ROLL_MIX, 4'd0, 8'h00);
		plan_cfg(CFG_DRUNK, 16'd0);
		plan_item(CMD_TICK, 7'd0, ROLL_MIX, 4'd0, 8'h00);
		plan_cfg(CFG_RANGE_START, 16'd12);
		plan_cfg(CFG_RANGE_END, 16'd3);
		repeat (2) plan_item(CMD_TICK, 7'd0, ROLL_MIX, 4'd0, 8'h00);
		plan_cfg(CFG_RANGE_START, 16'd15);
		plan_cfg(CFG_RANGE_END, 16'd15);
		plan_item(CMD_TICK, 7'd0, ROLL_MIX, 4'd0, 8'h00);
		plan_cfg(CFG_PROBABILITY, 16'd0);
		plan_item(CMD_TICK, 7'd0, '0, 4'd0, 8'h00);
		plan_cfg(CFG_PROBABILITY, 16'd100);
		plan_cfg(CFG_ONTIME, 16'hFFFF);
		plan_cfg(CFG_INTERVAL, 16'hFFFF);
		plan_item(CMD_TICK, 7'd0, '0, 4'd0, 8'h00);
		plan_cfg(CFG_RANGE_START, 16'd0);
		plan_cfg(CFG_INTERVAL, 16'd3);
		plan_cfg(CFG_ONTIME, 16'd2);
		repeat (5) plan_item(CMD_TICK, 7'd0, ROLL_MIX, 4'd0, 8'h00);
		plan_cfg(CFG_PLAYING, 16'd0);
		plan_item(CMD_TICK, 7'd0, '0, 4'd0, 8'h00);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_idle();
				cfg_write(plan[i].idx, plan[i].data);
			end else begin
				drive_beat(plan[i].cmd, plan[i].dir, plan[i].rolls, plan[i].gstep,
					plan[i].gbits, plan[i].typed, plan[i].want);
			end
		end

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			shuffle_cfg(p == 0);
			repeat (100) random_beat(1'b0);
		end

		// no idling from here on
		idle_on = 1'b0;

		// elapsed count runs on while stopped, then a short interval fires at once
		wait_idle();
		cfg_write(CFG_PLAYING, 16'd0);
		repeat (40) random_beat(1'b1);
		wait_idle();
		cfg_write(CFG_INTERVAL, 16'd20);
		cfg_write(CFG_PLAYING, 16'd1);
		repeat (20) random_beat(1'b1);

		wait_idle();
		shuffle_cfg(1'b1);
		repeat (100) random_beat(1'b0);

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_outs.size() == 0)
			$display("probabilistic_step_sequencer_top_tb: PASS");
		else
			$display("probabilistic_step_sequencer_top_tb: FAIL");
		$finish;
	end

endmodule

[probabilistic_step_sequencer_top.f]
+incdir+rtl
rtl/pss_pkg.sv
rtl/pss_gates.sv
rtl/probabilistic_step_sequencer_top.sv
tb/sv/probabilistic_step_sequencer_top_tb.sv
